// ===== sv/bst_pkg.sv =====
package bst_pkg;

    // field and register widths
    localparam int SAMPLE_W = 8;
    localparam int DIMREG_W = 12;
    localparam int POS_W    = 14;
    localparam int CFG_W    = 14;
    localparam int IDX_W    = 3;

    // effective dimension width, covers the largest allowed line or frame (4096)
    localparam int DIM_W = 13;

    // scale of the output coordinates
    localparam int unsigned SCALE = 10000;

    // defaults of the frame size limits
    localparam int MAX_LINE_DEF = 2048;
    localparam int MAX_ROWS_DEF = 2048;

    // depth of the frame queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // register map
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_JUMP_LIMIT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_START_X      = 3'd3;
    localparam logic [IDX_W-1:0] REG_START_Y      = 3'd4;

    // register reset values
    localparam logic [DIMREG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [DIMREG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [CFG_W-1:0]    JUMP_LIMIT_RST   = 14'd1500;
    localparam logic [POS_W-1:0]    START_X_RST      = 14'd960;
    localparam logic [POS_W-1:0]    START_Y_RST      = 14'd540;

    // start register write: reloads the last accepted point
    typedef struct packed {
        logic             ld_x;
        logic             ld_y;
        logic [POS_W-1:0] value;
    } t_start_ld;

endpackage

// ===== sv/bst_front.sv =====
module bst_front #(
    parameter int MAX_LINE = bst_pkg::MAX_LINE_DEF,
    parameter int MAX_ROWS = bst_pkg::MAX_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  logic [bst_pkg::SAMPLE_W-1:0]      i_sample,
    input  logic                              i_frame_end,
    input  logic [bst_pkg::DIMREG_W-1:0]      i_frame_width,
    input  logic [bst_pkg::DIMREG_W-1:0]      i_frame_height,
    output logic                              o_push,
    output logic [$clog2(MAX_LINE)+$clog2(MAX_ROWS)+2*bst_pkg::DIM_W-1:0] o_job
);

    localparam int CW = $clog2(MAX_LINE);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int DW = bst_pkg::DIM_W;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [bst_pkg::SAMPLE_W-1:0] r_best_val, n_best_val;
    logic [CW-1:0] r_best_col, n_best_col;
    logic [RW-1:0] r_best_row, n_best_row;

    logic [DW-1:0] w_eff, h_eff;
    logic          take_best;
    logic [CW-1:0] sel_col;
    logic [RW-1:0] sel_row;

    // zero counts as one, oversize clamps to the limit
    always_comb begin
        if (i_frame_width == '0) begin
            w_eff = DW'(1);
        end else if (DW'(i_frame_width) > DW'(MAX_LINE)) begin
            w_eff = DW'(MAX_LINE);
        end else begin
            w_eff = DW'(i_frame_width);
        end
        if (i_frame_height == '0) begin
            h_eff = DW'(1);
        end else if (DW'(i_frame_height) > DW'(MAX_ROWS)) begin
            h_eff = DW'(MAX_ROWS);
        end else begin
            h_eff = DW'(i_frame_height);
        end
    end

    // first pixel of a frame always wins, later only on strictly greater
    assign take_best = ((r_col == '0) && (r_row == '0)) || (i_sample > r_best_val);
    assign sel_col   = take_best ? r_col : r_best_col;
    assign sel_row   = take_best ? r_row : r_best_row;

    assign o_push = i_take && i_frame_end;
    assign o_job  = {sel_col, sel_row, w_eff, h_eff};

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_best_val = r_best_val;
        n_best_col = r_best_col;
        n_best_row = r_best_row;
        if (i_take) begin
            if (i_frame_end) begin
                n_col      = '0;
                n_row      = '0;
                n_best_val = '0;
                n_best_col = '0;
                n_best_row = '0;
            end else begin
                n_best_val = take_best ? i_sample : r_best_val;
                n_best_col = sel_col;
                n_best_row = sel_row;
                if ((DW'(r_col) + DW'(1)) >= w_eff) begin
                    n_col = '0;
                    if ((DW'(r_row) + DW'(1)) < h_eff) begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_best_val <= '0;
            r_best_col <= '0;
            r_best_row <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_best_val <= n_best_val;
            r_best_col <= n_best_col;
            r_best_row <= n_best_row;
        end
    end

endmodule

// ===== sv/bst_queue.sv =====
module bst_queue #(
    parameter int W = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    localparam int DEPTH = bst_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CNTW-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

endmodule

// ===== sv/bst_back.sv =====
module bst_back #(
    parameter int MAX_LINE = bst_pkg::MAX_LINE_DEF,
    parameter int MAX_ROWS = bst_pkg::MAX_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_LINE)+$clog2(MAX_ROWS)+2*bst_pkg::DIM_W-1:0] i_job,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  logic [bst_pkg::CFG_W-1:0]     i_jump_limit,
    input  bst_pkg::t_start_ld            i_start_ld,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bst_pkg::POS_W-1:0]     o_pos_x,
    output logic [bst_pkg::POS_W-1:0]     o_pos_y,
    output logic                          o_valid_res
);

    localparam int CW   = $clog2(MAX_LINE);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int DW   = bst_pkg::DIM_W;
    localparam int PW   = bst_pkg::POS_W;
    // numerator and quotient width: index times the scale
    localparam int NW   = ((CW > RW) ? CW : RW) + PW;
    localparam int CNTW = $clog2(NW);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIVX  = 4'b0010,
        S_DIVY  = 4'b0100,
        S_CHECK = 4'b1000
    } t_state;

    t_state r_state;

    logic [CW-1:0] job_col;
    logic [RW-1:0] job_row;
    logic [DW-1:0] job_w, job_h;

    logic [NW-1:0]   r_num, r_ynum, r_sx, r_last_x, r_last_y;
    logic [DW-1:0]   r_rem, r_den, r_yden;
    logic [CNTW-1:0] r_cnt;

    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_num;

    logic [NW-1:0] dx, dy;
    logic          pass, out_free, load_out;

    logic [PW-1:0] r_pos_x, r_pos_y;
    logic          r_out_valid, r_valid_res;

    assign {job_col, job_row, job_w, job_h} = i_job;
    assign o_pop = (r_state == S_IDLE) && !i_empty;

    // one restoring division step a cycle
    assign rem_sh = {r_rem, r_num[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign n_rem  = ge ? DW'(rem_sh - {1'b0, r_den}) : DW'(rem_sh);
    assign n_num  = {r_num[NW-2:0], ge};

    // r_num holds the y quotient in the check state
    assign dx       = (r_sx > r_last_x) ? r_sx - r_last_x : r_last_x - r_sx;
    assign dy       = (r_num > r_last_y) ? r_num - r_last_y : r_last_y - r_num;
    assign pass     = (dx < NW'(i_jump_limit)) && (dy < NW'(i_jump_limit));
    assign out_free = !r_out_valid || !i_stall;
    assign load_out = (r_state == S_CHECK) && out_free;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_num  <= NW'(job_col) * NW'(bst_pkg::SCALE);
                r_ynum <= NW'(job_row) * NW'(bst_pkg::SCALE);
                r_den  <= job_w;
                r_yden <= job_h;
                r_rem  <= '0;
                r_cnt  <= CNTW'(NW - 1);
            end
            S_DIVX: begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    r_sx  <= n_num;
                    r_num <= r_ynum;
                    r_den <= r_yden;
                    r_rem <= '0;
                    r_cnt <= CNTW'(NW - 1);
                end else begin
                    r_num <= n_num;
                    r_rem <= n_rem;
                end
            end
            S_DIVY: begin
                r_cnt <= r_cnt - CNTW'(1);
                r_num <= n_num;
                r_rem <= n_rem;
            end
            default: begin
            end
        endcase
        if (load_out) begin
            r_pos_x     <= pass ? PW'(NW'(bst_pkg::SCALE) - r_sx) : '0;
            r_pos_y     <= pass ? PW'(r_num) : '0;
            r_valid_res <= pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last_x    <= NW'(bst_pkg::START_X_RST);
            r_last_y    <= NW'(bst_pkg::START_Y_RST);
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (r_cnt == '0) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_start_ld.ld_x) begin
                r_last_x <= NW'(i_start_ld.value);
            end else if (load_out && pass) begin
                r_last_x <= r_sx;
            end
            if (i_start_ld.ld_y) begin
                r_last_y <= NW'(i_start_ld.value);
            end else if (load_out && pass) begin
                r_last_y <= r_num;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_valid_res = r_valid_res;

`ifndef SYNTH
    a_pop_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty frame queue");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_pos_x == '0) && (o_pos_y == '0))
        else $error("rejected spot carries a position");

    a_divx_to_divy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIVX) && (r_cnt == '0)) |=> (r_state == S_DIVY))
        else $error("x division did not hand over to y");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && pass && !i_start_ld.ld_x) |=> (r_last_x == $past(r_sx)))
        else $error("accepted spot not stored");

    a_out_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (o_valid && (r_state == S_IDLE)))
        else $error("result load did not present an item");
`endif

endmodule

// ===== sv/bright_spot_tracker.sv =====
// Pixel side: one item per cycle; i_valid is taken whenever the two-entry frame
//   queue has room (o_stall = queue full).
// Result: the frame_end item pushes a job into the queue, the back end pops it, the
//   bit-serial divider computes x then y, and the check loads the output register.
// Short frames can fill the queue before the divider drains it, stalling the pixel side.
// Reset (synchronous, active low): registers to defaults, counters and best spot cleared.
module bright_spot_tracker #(
    parameter int MAX_LINE = bst_pkg::MAX_LINE_DEF,
    parameter int MAX_ROWS = bst_pkg::MAX_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel items
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bst_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                            i_frame_end,
    // result items
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [bst_pkg::POS_W-1:0]       o_pos_x,
    output logic [bst_pkg::POS_W-1:0]       o_pos_y,
    output logic                            o_valid_res,
    // register writes
    input  logic                            i_cfg_we,
    input  logic [bst_pkg::IDX_W-1:0]       i_cfg_idx,
    input  logic [bst_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int JW = $clog2(MAX_LINE) + $clog2(MAX_ROWS) + 2 * bst_pkg::DIM_W;

    // config registers
    logic [bst_pkg::DIMREG_W-1:0] r_frame_width;
    logic [bst_pkg::DIMREG_W-1:0] r_frame_height;
    logic [bst_pkg::CFG_W-1:0]    r_jump_limit;
    bst_pkg::t_start_ld           start_ld;

    // front to queue to back
    logic          take, push, pop, q_empty, q_full;
    logic [JW-1:0] job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bst_pkg::FRAME_WIDTH_RST;
            r_frame_height <= bst_pkg::FRAME_HEIGHT_RST;
            r_jump_limit   <= bst_pkg::JUMP_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bst_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[bst_pkg::DIMREG_W-1:0];
                bst_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[bst_pkg::DIMREG_W-1:0];
                bst_pkg::REG_JUMP_LIMIT:   r_jump_limit   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // start writes go straight into the back end's last accepted point
    assign start_ld.ld_x  = i_cfg_we && (i_cfg_idx == bst_pkg::REG_START_X);
    assign start_ld.ld_y  = i_cfg_we && (i_cfg_idx == bst_pkg::REG_START_Y);
    assign start_ld.value = i_cfg_wdata;

    // the pixel side only stalls on a full frame queue
    assign o_stall = q_full;
    assign take    = i_valid && !q_full;

    bst_front #(
        .MAX_LINE (MAX_LINE),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_sample       (i_sample),
        .i_frame_end    (i_frame_end),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_push         (push),
        .o_job          (job_in)
    );

    bst_queue #(
        .W (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    bst_back #(
        .MAX_LINE (MAX_LINE),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job_out),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .i_jump_limit (r_jump_limit),
        .i_start_ld   (start_ld),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_valid_res  (o_valid_res)
    );

endmodule
